// File: hdl/rdq_pkg.sv
`default_nettype none
package rdq_pkg;

	localparam int DATA_W   = 32;
	localparam int OCC_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_RESTRICT_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY      = 2'd1;

	localparam logic MODE_INPUT_RESTRICTED  = 1'b0;
	localparam logic MODE_OUTPUT_RESTRICTED = 1'b1;

	typedef enum logic [1:0] {
		OP_INS_RIGHT = 2'd0,
		OP_INS_LEFT  = 2'd1,
		OP_POP_LEFT  = 2'd2,
		OP_POP_RIGHT = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_DENIED = 2'd3
	} status_t;

	typedef struct packed {
		op_t                      op;
		logic signed [DATA_W-1:0] data_in;
	} in_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] data_out;
		logic [OCC_W-1:0]         occupancy;
	} out_t;

	// per-item result from the pointer unit to the output stage
	typedef struct packed {
		status_t          status;
		logic             pop_ok;
		logic [OCC_W-1:0] occupancy;
	} res_t;

endpackage
`default_nettype wire

// File: hdl/rdq_ram.sv
`default_nettype none
module rdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/rdq_ctrl.sv
`default_nettype none
module rdq_ctrl #(
	parameter int DEPTH = 128
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	input  wire logic [rdq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [rdq_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                accept,
	input  wire rdq_pkg::op_t                        op,
	output rdq_pkg::res_t                            res,
	output logic                                     ram_we,
	output logic [$clog2(DEPTH)-1:0]                 ram_waddr,
	output logic [$clog2(DEPTH)-1:0]                 ram_raddr
);

	localparam int IW = $clog2(DEPTH);
	localparam logic [7:0] CAP_MAX  = (DEPTH > 255) ? 8'd255 : 8'(DEPTH);
	localparam logic [7:0] RST_CAP  = (DEPTH < 128) ? 8'(DEPTH) : 8'd128;
	localparam logic [IW-1:0] RST_LAST = IW'(RST_CAP - 8'd1);

	logic          mode_q;
	logic [7:0]    cap_eff_q;
	logic [IW-1:0] last_q;
	logic [7:0]    count_q;
	logic [IW-1:0] left_q;
	logic [IW-1:0] right_q;

	logic [7:0]    cfg_cap;
	logic [IW-1:0] left_inc, left_dec, right_inc, right_dec;
	logic          allowed, full, empty;

	logic [7:0]    count_d;
	logic [IW-1:0] left_d, right_d;

	// effective capacity of a written value
	always_comb begin
		if (cfg_data == 8'd0) begin
			cfg_cap = 8'd1;
		end else if (cfg_data > CAP_MAX) begin
			cfg_cap = CAP_MAX;
		end else begin
			cfg_cap = cfg_data;
		end
	end

	assign left_inc  = (left_q == last_q) ? '0 : left_q + 1'b1;
	assign left_dec  = (left_q == '0) ? last_q : left_q - 1'b1;
	assign right_inc = (right_q == last_q) ? '0 : right_q + 1'b1;
	assign right_dec = (right_q == '0) ? last_q : right_q - 1'b1;

	assign full  = (count_q >= cap_eff_q);
	assign empty = (count_q == 8'd0);

	always_comb begin
		if (mode_q == rdq_pkg::MODE_INPUT_RESTRICTED) begin
			allowed = (op != rdq_pkg::OP_INS_LEFT);
		end else begin
			allowed = (op != rdq_pkg::OP_POP_RIGHT);
		end
	end

	always_comb begin
		res.status    = rdq_pkg::ST_OK;
		res.pop_ok    = 1'b0;
		count_d       = count_q;
		left_d        = left_q;
		right_d       = right_q;
		ram_we        = 1'b0;
		ram_waddr     = right_inc;
		ram_raddr     = left_q;
		unique case (op)
			rdq_pkg::OP_INS_RIGHT: begin
				ram_waddr = right_inc;
				if (!allowed) begin
					res.status = rdq_pkg::ST_DENIED;
				end else if (full) begin
					res.status = rdq_pkg::ST_FULL;
				end else begin
					ram_we  = accept;
					right_d = right_inc;
					count_d = count_q + 8'd1;
				end
			end
			rdq_pkg::OP_INS_LEFT: begin
				ram_waddr = left_dec;
				if (!allowed) begin
					res.status = rdq_pkg::ST_DENIED;
				end else if (full) begin
					res.status = rdq_pkg::ST_FULL;
				end else begin
					ram_we  = accept;
					left_d  = left_dec;
					count_d = count_q + 8'd1;
				end
			end
			rdq_pkg::OP_POP_LEFT: begin
				ram_raddr = left_q;
				if (!allowed) begin
					res.status = rdq_pkg::ST_DENIED;
				end else if (empty) begin
					res.status = rdq_pkg::ST_EMPTY;
				end else begin
					res.pop_ok = 1'b1;
					left_d     = left_inc;
					count_d    = count_q - 8'd1;
				end
			end
			rdq_pkg::OP_POP_RIGHT: begin
				ram_raddr = right_q;
				if (!allowed) begin
					res.status = rdq_pkg::ST_DENIED;
				end else if (empty) begin
					res.status = rdq_pkg::ST_EMPTY;
				end else begin
					res.pop_ok = 1'b1;
					right_d    = right_dec;
					count_d    = count_q - 8'd1;
				end
			end
			default: begin
				res.status = rdq_pkg::ST_DENIED;
			end
		endcase
		res.occupancy = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= rdq_pkg::MODE_INPUT_RESTRICTED;
			cap_eff_q <= RST_CAP;
			last_q    <= RST_LAST;
			count_q   <= 8'd0;
			left_q    <= '0;
			right_q   <= RST_LAST;
		end else if (cfg_valid) begin
			if (cfg_index == rdq_pkg::CFG_RESTRICT_MODE) begin
				mode_q <= cfg_data[0];
			end else if (cfg_index == rdq_pkg::CFG_CAPACITY) begin
				cap_eff_q <= cfg_cap;
				last_q    <= IW'(cfg_cap - 8'd1);
				count_q   <= 8'd0;
				left_q    <= '0;
				right_q   <= IW'(cfg_cap - 8'd1);
			end
		end else if (accept) begin
			count_q <= count_d;
			left_q  <= left_d;
			right_q <= right_d;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_eff_q)
		else $error("count above capacity");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 8'd0 |-> right_q == left_dec)
		else $error("empty deque with misaligned ends");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cfg_valid && res.status == rdq_pkg::ST_OK &&
		(op == rdq_pkg::OP_INS_RIGHT || op == rdq_pkg::OP_INS_LEFT)
		|=> count_q == $past(count_q) + 8'd1)
		else $error("insert did not grow count");

	a_fail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cfg_valid && res.status != rdq_pkg::ST_OK
		|=> $stable(count_q) && $stable(left_q) && $stable(right_q))
		else $error("failed operation changed state");
`endif

endmodule
`default_nettype wire

// File: hdl/restricted_circular_deque.sv
// restricted_circular_deque
// Double-ended queue of signed 32-bit words held in one synchronous RAM.
// in channel: in_valid/in_stall with in_data (op, data_in); an item transfers
// at a clock edge with in_valid high and in_stall low.
// out channel: out_valid/out_stall with out_data (status, data_out, occupancy);
// one result per item, in order.
// cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is the
// restrict mode, index 1 the capacity (writing it empties the deque). Other
// indexes are ignored. cfg_ready is always high; write only while idle.
// Pipeline: the RAM read and res_s1 are registered at the input transfer, and
// the output register takes them over once it is empty or not stalled.
// Throughput: one item per cycle while in_stall is low; pointers and count
// update at the input transfer, so a pop right after an insert reads the
// written word. When out_stall holds a result, one more item is taken into
// the read stage and then in_stall rises until the output register drains.
// Reset: mode input restricted, capacity 128 (or DEPTH if smaller), empty.
// RAM contents are not cleared; only written entries ever reach data_out.
`default_nettype none
module restricted_circular_deque #(
	parameter int DEPTH = 128
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire rdq_pkg::in_t                       in_data,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output rdq_pkg::out_t                           out_data,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [rdq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rdq_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int IW = $clog2(DEPTH);

	logic                       accept;
	logic                       advance;
	rdq_pkg::res_t              res;
	logic                       ram_we;
	logic [IW-1:0]              ram_waddr;
	logic [IW-1:0]              ram_raddr;
	logic [rdq_pkg::DATA_W-1:0] ram_rdata;

	logic                       s1_valid_q;
	rdq_pkg::res_t              res_s1;
	logic                       out_valid_q;
	rdq_pkg::out_t              out_data_q;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = s1_valid_q && !advance;
	assign accept    = in_valid && !in_stall;

	rdq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.op        (in_data.op),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_raddr (ram_raddr)
	);

	rdq_ram #(
		.WIDTH(rdq_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_data.data_in),
		.re    (accept),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				s1_valid_q <= in_valid;
			end
			if (advance) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
		if (advance && s1_valid_q) begin
			out_data_q.status    <= res_s1.status;
			out_data_q.data_out  <= res_s1.pop_ok ? ram_rdata : '0;
			out_data_q.occupancy <= res_s1.occupancy;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

// File: bench/restricted_circular_deque_test.sv
`default_nettype none
module restricted_circular_deque_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rdq_pkg::*;

	localparam int DEPTH = 128;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd2;

	typedef struct packed {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  cfg_idx;
		logic [CFG_DATA_W-1:0] cfg_val;
		in_t                   item;
		logic                  typed;
		out_t                  want;
	} dir_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// deque shadow state
	logic [DATA_W-1:0] dq_words [DEPTH];
	int unsigned dq_left;
	int unsigned dq_right;
	int unsigned dq_count;
	logic dq_mode;
	logic [CFG_DATA_W-1:0] dq_cap;

	out_t result_q [$];
	out_t want_res;
	dir_row_t dir_tab [$];

	int errors = 0;
	int cycle_cnt = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	restricted_circular_deque u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned eff_capacity();
		int unsigned c;
		c = dq_cap;
		if (c == 0) c = 1;
		if (c > DEPTH) c = DEPTH;
		return c;
	endfunction

	function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		if (idx == CFG_RESTRICT_MODE) begin
			dq_mode = val[0];
		end else if (idx == CFG_CAPACITY) begin
			dq_cap = val;
			dq_count = 0;
			dq_left = 0;
			dq_right = eff_capacity() - 1;
		end
	endfunction

	function automatic out_t deque_step(in_t item);
		out_t res;
		int unsigned cap;
		logic allowed;
		cap = eff_capacity();
		res.status = ST_OK;
		res.data_out = '0;
		if (dq_mode == MODE_INPUT_RESTRICTED) allowed = (item.op != OP_INS_LEFT);
		else allowed = (item.op != OP_POP_RIGHT);
		dq_left = dq_left % cap;
		dq_right = dq_right % cap;
		if (!allowed) begin
			res.status = ST_DENIED;
		end else if (item.op == OP_INS_RIGHT || item.op == OP_INS_LEFT) begin
			if (dq_count >= cap) begin
				res.status = ST_FULL;
			end else if (item.op == OP_INS_RIGHT) begin
				dq_right = (dq_right + 1) % cap;
				dq_words[dq_right] = item.data_in;
				dq_count++;
			end else begin
				dq_left = (dq_left + cap - 1) % cap;
				dq_words[dq_left] = item.data_in;
				dq_count++;
			end
		end else if (dq_count == 0) begin
			res.status = ST_EMPTY;
		end else if (item.op == OP_POP_LEFT) begin
			res.data_out = dq_words[dq_left];
			dq_left = (dq_left + 1) % cap;
			dq_count--;
		end else begin
			res.data_out = dq_words[dq_right];
			dq_right = (dq_right + cap - 1) % cap;
			dq_count--;
		end
		res.occupancy = OCC_W'(dq_count);
		return res;
	endfunction

	function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		dir_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.cfg_idx = idx;
		r.cfg_val = val;
		return r;
	endfunction

	function automatic dir_row_t op_row(op_t op, logic [DATA_W-1:0] d);
		dir_row_t r;
		r = '0;
		r.item.op = op;
		r.item.data_in = d;
		return r;
	endfunction

	function automatic dir_row_t chk_row(op_t op, logic [DATA_W-1:0] d, status_t st,
			logic [DATA_W-1:0] dout, logic [OCC_W-1:0] occ);
		dir_row_t r;
		r = op_row(op, d);
		r.typed = 1'b1;
		r.want.status = st;
		r.want.data_out = dout;
		r.want.occupancy = occ;
		return r;
	endfunction

	task automatic wait_results();
		while (result_q.size() != 0) @(posedge clk);
	endtask

	// caller has already lowered in_valid
	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		wait_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_cfg(idx, val);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(in_t item, logic typed, out_t typed_res);
		out_t res;
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
		res = deque_step(item);
		result_q.push_back(typed ? typed_res : res);
	endtask

	// receiver: random stall, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				$error("result with no transfer pending: status %0d data_out %h occupancy %0d",
					out_data.status, out_data.data_out, out_data.occupancy);
				errors++;
			end else begin
				want_res = result_q.pop_front();
				if (out_data.status !== want_res.status) begin
					$error("status: expected %0d, got %0d", want_res.status, out_data.status);
					errors++;
				end
				if (out_data.data_out !== want_res.data_out) begin
					$error("data_out: expected %h, got %h", want_res.data_out, out_data.data_out);
					errors++;
				end
				if (out_data.occupancy !== want_res.occupancy) begin
					$error("occupancy: expected %0d, got %0d",
						want_res.occupancy, out_data.occupancy);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("** restricted_circular_deque: FAILED **");
			$finish;
		end
	end

	initial begin
		int n_items;
		int ins_pct;
		int r;
		logic [CFG_DATA_W-1:0] cap_val;
		in_t item;
		op_t op;

		dq_mode = MODE_INPUT_RESTRICTED;
		apply_cfg(CFG_CAPACITY, 8'd128);

		// empty pops, denied insert, extreme words
		dir_tab.push_back(chk_row(OP_POP_LEFT, 32'h0, ST_EMPTY, 32'h0, 8'd0));
		dir_tab.push_back(chk_row(OP_POP_RIGHT, 32'hffffffff, ST_EMPTY, 32'h0, 8'd0));
		dir_tab.push_back(chk_row(OP_INS_LEFT, 32'h1, ST_DENIED, 32'h0, 8'd0));
		dir_tab.push_back(chk_row(OP_INS_RIGHT, 32'h7fffffff, ST_OK, 32'h0, 8'd1));
		dir_tab.push_back(chk_row(OP_INS_RIGHT, 32'h80000000, ST_OK, 32'h0, 8'd2));
		dir_tab.push_back(chk_row(OP_POP_RIGHT, 32'h0, ST_OK, 32'h80000000, 8'd1));
		dir_tab.push_back(chk_row(OP_POP_LEFT, 32'h0, ST_OK, 32'h7fffffff, 8'd0));
		// capacity one: full, then mode change keeps the entry
		dir_tab.push_back(cfg_row(CFG_CAPACITY, 8'd1));
		dir_tab.push_back(chk_row(OP_INS_RIGHT, 32'hffffffff, ST_OK, 32'h0, 8'd1));
		dir_tab.push_back(chk_row(OP_INS_RIGHT, 32'h0, ST_FULL, 32'h0, 8'd1));
		dir_tab.push_back(cfg_row(CFG_RESTRICT_MODE, 8'hff));
		dir_tab.push_back(chk_row(OP_POP_RIGHT, 32'h0, ST_DENIED, 32'h0, 8'd1));
		dir_tab.push_back(chk_row(OP_INS_LEFT, 32'h5, ST_FULL, 32'h0, 8'd1));
		dir_tab.push_back(chk_row(OP_POP_LEFT, 32'h0, ST_OK, 32'hffffffff, 8'd0));
		dir_tab.push_back(chk_row(OP_INS_LEFT, 32'h55555555, ST_OK, 32'h0, 8'd1));
		// capacity zero acts as one and empties the deque
		dir_tab.push_back(cfg_row(CFG_CAPACITY, 8'd0));
		dir_tab.push_back(chk_row(OP_POP_LEFT, 32'h0, ST_EMPTY, 32'h0, 8'd0));
		dir_tab.push_back(chk_row(OP_INS_LEFT, 32'haaaaaaaa, ST_OK, 32'h0, 8'd1));
		dir_tab.push_back(chk_row(OP_INS_LEFT, 32'h12345678, ST_FULL, 32'h0, 8'd1));
		dir_tab.push_back(chk_row(OP_POP_LEFT, 32'h0, ST_OK, 32'haaaaaaaa, 8'd0));
		// capacity above depth, left insert at index zero wraps
		dir_tab.push_back(cfg_row(CFG_CAPACITY, 8'd255));
		dir_tab.push_back(op_row(OP_INS_LEFT, 32'h1));
		dir_tab.push_back(op_row(OP_INS_RIGHT, 32'h2));
		dir_tab.push_back(cfg_row(CFG_UNUSED, 8'hff));
		dir_tab.push_back(op_row(OP_POP_LEFT, 32'h0));
		dir_tab.push_back(chk_row(OP_POP_RIGHT, 32'h0, ST_DENIED, 32'h0, 8'd1));
		dir_tab.push_back(cfg_row(CFG_RESTRICT_MODE, 8'hfe));
		dir_tab.push_back(op_row(OP_POP_RIGHT, 32'h0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		snd_idle_pct = 36;
		rcv_idle_pct = 61;
		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				in_valid <= 1'b0;
				write_cfg(dir_tab[i].cfg_idx, dir_tab[i].cfg_val);
			end else begin
				send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
			end
		end

		for (int regime = 0; regime < 3; regime++) begin
			case (regime)
				0: begin
					snd_idle_pct = 36;
					rcv_idle_pct = 61;
				end
				1: begin
					snd_idle_pct = 61;
					rcv_idle_pct = 36;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			for (int ph = 0; ph < 5; ph++) begin
				in_valid <= 1'b0;
				write_cfg(CFG_RESTRICT_MODE, {7'($urandom_range(127)), 1'($urandom_range(1))});
				case (ph)
					0: cap_val = 8'($urandom_range(1, 4));
					1: cap_val = 8'($urandom_range(5, 16));
					2: cap_val = $urandom_range(1) ? 8'd128 : 8'd255;
					3: cap_val = 8'($urandom_range(1, 255));
					default: cap_val = 8'($urandom_range(2));
				endcase
				write_cfg(CFG_CAPACITY, cap_val);
				n_items = (ph == 2) ? 160 : 100;
				ins_pct = 50;
				if (regime == 2 && ph == 0) hold_request = 1'b1;
				for (int n = 0; n < n_items; n++) begin
					if (n == n_items / 2) begin
						in_valid <= 1'b0;
						write_cfg(CFG_RESTRICT_MODE,
							{7'($urandom_range(127)), 1'($urandom_range(1))});
					end
					if (n % 25 == 0) begin
						ins_pct = 15 + 35 * $urandom_range(2);
						if (ph == 2 && n < 100) ins_pct = 95;
					end
					r = $urandom_range(99);
					if (r < 8) begin
						op = (dq_mode == MODE_INPUT_RESTRICTED) ? OP_INS_LEFT : OP_POP_RIGHT;
					end else if ($urandom_range(99) < ins_pct) begin
						if (dq_mode == MODE_INPUT_RESTRICTED) op = OP_INS_RIGHT;
						else op = $urandom_range(1) ? OP_INS_LEFT : OP_INS_RIGHT;
					end else begin
						if (dq_mode == MODE_INPUT_RESTRICTED)
							op = $urandom_range(1) ? OP_POP_LEFT : OP_POP_RIGHT;
						else op = OP_POP_LEFT;
					end
					item.op = op;
					item.data_in = $urandom;
					send_item(item, 1'b0, '0);
				end
			end
		end

		in_valid <= 1'b0;
		wait_results();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("** restricted_circular_deque: PASSED **");
		end else begin
			$display("** restricted_circular_deque: FAILED **");
		end
		$finish;
	end

endmodule
`default_nettype wire
